// ----- src/oas_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oas_pkg
// Shared types and constants for the obstacle avoidance sequencer.
// ----------------------------------------------------------------------------
package oas_pkg;

  localparam logic [1:0] OP_POINT  = 2'd0;
  localparam logic [1:0] OP_CLOUD  = 2'd1;
  localparam logic [1:0] OP_MARKER = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_LEFT  = 2'd1;
  localparam logic [1:0] CMD_RIGHT = 2'd2;
  localparam logic [1:0] CMD_FWD   = 2'd3;

  localparam logic [2:0] REG_NEAR  = 3'd0;
  localparam logic [2:0] REG_FAR   = 3'd1;
  localparam logic [2:0] REG_HALF  = 3'd2;
  localparam logic [2:0] REG_BAND  = 3'd3;
  localparam logic [2:0] REG_CLEAR = 3'd4;
  localparam logic [2:0] REG_TURN  = 3'd5;
  localparam logic [2:0] REG_MOVE  = 3'd6;

  localparam logic [14:0] NEAR_RST  = 15'd800;
  localparam logic [14:0] FAR_RST   = 15'd6000;
  localparam logic [14:0] HALF_RST  = 15'd700;
  localparam logic [14:0] BAND_RST  = 15'd350;
  localparam logic [7:0]  CLEAR_RST = 8'd6;
  localparam logic [7:0]  TURN_RST  = 8'd25;
  localparam logic [7:0]  MOVE_RST  = 8'd60;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] point_x_mm;
    logic signed [15:0] point_y_mm;
    logic               point_valid;
    logic               marker_seen;
  } in_item_t;

  typedef struct packed {
    logic       avoid_active;
    logic [1:0] drive_command;
  } out_item_t;

  typedef struct packed {
    logic [14:0] near_limit_mm;
    logic [14:0] far_limit_mm;
    logic [14:0] half_width_mm;
    logic [14:0] side_band_mm;
    logic [7:0]  clear_clouds;
    logic [7:0]  turn_ticks;
    logic [7:0]  move_ticks;
  } cfg_t;

  typedef struct packed {
    logic               flag;
    logic signed [15:0] lateral;
  } obs_t;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_TURN = 3'b010,
    MODE_MOVE = 3'b100
  } mode_t;

  function automatic logic [7:0] inc_sat8(input logic [7:0] v);
    return (v == 8'hFF) ? 8'hFF : v + 8'd1;
  endfunction

endpackage

// ----- src/oas_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oas_scan
// Forward box test, nearest point tracking and obstacle latch / clear.
// ----------------------------------------------------------------------------
module oas_scan import oas_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     item_vld,
  input  in_item_t item,
  input  cfg_t     cfg,
  input  logic     obs_clear,
  output obs_t     obs
);

  logic               found_r, found_nxt;
  logic signed [15:0] best_x_r, best_x_nxt;
  logic signed [15:0] best_y_r, best_y_nxt;
  logic               flag_r, flag_nxt;
  logic signed [15:0] lat_r, lat_nxt;
  logic [7:0]         empty_r, empty_nxt;

  logic signed [16:0] px, py, near_s, far_s, half_s;
  logic               in_box;
  logic [7:0]         empty_inc;

  assign px     = 17'(item.point_x_mm);
  assign py     = 17'(item.point_y_mm);
  assign near_s = $signed({2'b00, cfg.near_limit_mm});
  assign far_s  = $signed({2'b00, cfg.far_limit_mm});
  assign half_s = $signed({2'b00, cfg.half_width_mm});

  assign in_box = item.point_valid && (px >= near_s) && (px <= far_s) &&
                  (py >= -half_s) && (py <= half_s);
  assign empty_inc = inc_sat8(empty_r);

  always_comb begin
    found_nxt  = found_r;
    best_x_nxt = best_x_r;
    best_y_nxt = best_y_r;
    flag_nxt   = flag_r;
    lat_nxt    = lat_r;
    empty_nxt  = empty_r;
    if (obs_clear) begin
      flag_nxt  = 1'b0;
      lat_nxt   = '0;
      empty_nxt = '0;
    end
    if (item_vld) begin
      case (item.opcode)
        OP_POINT: begin
          if (in_box && (!found_r || item.point_x_mm < best_x_r)) begin
            found_nxt  = 1'b1;
            best_x_nxt = item.point_x_mm;
            best_y_nxt = item.point_y_mm;
          end
        end
        OP_CLOUD: begin
          if (found_r) begin
            flag_nxt  = 1'b1;
            empty_nxt = '0;
            lat_nxt   = best_y_r;
          end else if (flag_r) begin
            if (empty_inc >= cfg.clear_clouds) begin
              flag_nxt  = 1'b0;
              lat_nxt   = '0;
              empty_nxt = '0;
            end else begin
              empty_nxt = empty_inc;
            end
          end
          found_nxt  = 1'b0;
          best_x_nxt = '0;
          best_y_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r  <= 1'b0;
      best_x_r <= '0;
      best_y_r <= '0;
      flag_r   <= 1'b0;
      lat_r    <= '0;
      empty_r  <= '0;
    end else begin
      found_r  <= found_nxt;
      best_x_r <= best_x_nxt;
      best_y_r <= best_y_nxt;
      flag_r   <= flag_nxt;
      lat_r    <= lat_nxt;
      empty_r  <= empty_nxt;
    end
  end

  assign obs.flag    = flag_r;
  assign obs.lateral = lat_r;

endmodule

// ----- src/oas_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oas_ctrl
// Marker flag and idle / turning / moving-clear mode machine, run on ticks.
// ----------------------------------------------------------------------------
module oas_ctrl import oas_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_vld,
  input  in_item_t  item,
  input  cfg_t      cfg,
  input  obs_t      obs,
  output logic      obs_clear,
  output out_item_t res
);

  mode_t      mode_r, mode_nxt;
  logic [7:0] step_r, step_nxt;
  logic       left_r, left_nxt;
  logic       marker_r, marker_nxt;

  logic               tick;
  logic [7:0]         step_inc;
  logic signed [16:0] lat_s, band_s;

  assign tick     = item_vld && (item.opcode == OP_TICK);
  assign step_inc = inc_sat8(step_r);
  assign lat_s    = 17'(obs.lateral);
  assign band_s   = $signed({2'b00, cfg.side_band_mm});

  always_comb begin
    mode_nxt          = mode_r;
    step_nxt          = step_r;
    left_nxt          = left_r;
    marker_nxt        = marker_r;
    obs_clear         = 1'b0;
    res.avoid_active  = 1'b0;
    res.drive_command = CMD_NONE;
    if (item_vld && item.opcode == OP_MARKER) begin
      marker_nxt = item.marker_seen;
    end
    unique case (mode_r)
      MODE_TURN: begin
        res.avoid_active  = 1'b1;
        res.drive_command = left_r ? CMD_LEFT : CMD_RIGHT;
        if (tick) begin
          if (step_inc >= cfg.turn_ticks) begin
            step_nxt = '0;
            mode_nxt = MODE_MOVE;
          end else begin
            step_nxt = step_inc;
          end
        end
      end
      MODE_MOVE: begin
        res.avoid_active  = 1'b1;
        res.drive_command = CMD_FWD;
        if (tick) begin
          if (step_inc >= cfg.move_ticks) begin
            step_nxt  = '0;
            mode_nxt  = MODE_IDLE;
            obs_clear = 1'b1;
          end else if (obs.flag) begin
            left_nxt = obs.lateral < 0;
            step_nxt = '0;
            mode_nxt = MODE_TURN;
          end else begin
            step_nxt = step_inc;
          end
        end
      end
      default: begin
        if (tick) begin
          mode_nxt = MODE_IDLE;
          if (obs.flag) begin
            if (lat_s < -band_s) begin
              left_nxt = 1'b1;
            end else if (lat_s > band_s) begin
              left_nxt = 1'b0;
            end else begin
              left_nxt = marker_r;
            end
            step_nxt = '0;
            mode_nxt = MODE_TURN;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      step_r   <= '0;
      left_r   <= 1'b0;
      marker_r <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      step_r   <= step_nxt;
      left_r   <= left_nxt;
      marker_r <= marker_nxt;
    end
  end

endmodule

// ----- src/obstacle_avoid_sequencer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obstacle_avoid_sequencer_core
// Opcode-driven obstacle detector and avoidance sequencer, top level.
// ----------------------------------------------------------------------------
//  channel | ports                           | payload
//  in      | in_valid  in_ready  in_data     | in_item_t, one item per transfer
//  out     | out_valid out_ready out_data    | out_item_t, one per tick item
//  cfg     | cfg_valid cfg_ready cfg_index   | cfg_data, registers 0..6
//
//  One item per cycle unless a tick is held: an input register, then the state
//  update and a result register.
//  A tick waits in the input register only while the result register is full
//  and not taken; other opcodes never stall. cfg_ready is always high.
//  Synchronous active-low reset restores default limits and idle state.
// ----------------------------------------------------------------------------
module obstacle_avoid_sequencer_core import oas_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  cfg_t      cfg_r;
  in_item_t  item_r;
  logic      item_vld_r;
  out_item_t res_r;
  logic      res_vld_r;

  logic      out_free, fire, is_tick;
  obs_t      obs;
  logic      obs_clear;
  out_item_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.near_limit_mm <= NEAR_RST;
      cfg_r.far_limit_mm  <= FAR_RST;
      cfg_r.half_width_mm <= HALF_RST;
      cfg_r.side_band_mm  <= BAND_RST;
      cfg_r.clear_clouds  <= CLEAR_RST;
      cfg_r.turn_ticks    <= TURN_RST;
      cfg_r.move_ticks    <= MOVE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_NEAR:  cfg_r.near_limit_mm <= cfg_data;
        REG_FAR:   cfg_r.far_limit_mm  <= cfg_data;
        REG_HALF:  cfg_r.half_width_mm <= cfg_data;
        REG_BAND:  cfg_r.side_band_mm  <= cfg_data;
        REG_CLEAR: cfg_r.clear_clouds  <= cfg_data[7:0];
        REG_TURN:  cfg_r.turn_ticks    <= cfg_data[7:0];
        REG_MOVE:  cfg_r.move_ticks    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign out_free = !res_vld_r || out_ready;
  assign is_tick  = (item_r.opcode == OP_TICK);
  assign fire     = item_vld_r && (!is_tick || out_free);
  assign in_ready = !item_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_data;
    end
  end

  oas_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (fire),
    .item      (item_r),
    .cfg       (cfg_r),
    .obs_clear (obs_clear),
    .obs       (obs)
  );

  oas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (fire),
    .item      (item_r),
    .cfg       (cfg_r),
    .obs       (obs),
    .obs_clear (obs_clear),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (fire && is_tick) begin
      res_vld_r <= 1'b1;
    end else if (out_ready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_tick) begin
      res_r <= res;
    end
  end

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

endmodule
